>>> sv/jasp_pkg.sv
// Package for the JPEG APP segment stripper.
// Holds the item types, parser phase codes and marker byte constants.
// No dependencies; every other file imports it.
package jasp_pkg;

   // Marker byte values seen in the stream.
   localparam logic [7:0] MARK_BYTE = 8'hFF;
   localparam logic [7:0] SOI_BYTE  = 8'hD8;
   localparam logic [7:0] APP_MASK  = 8'hF0;
   localparam logic [7:0] APP_BASE  = 8'hE0;
   localparam logic [7:0] COM_BYTE  = 8'hFE;
   localparam logic [7:0] APP2_BYTE = 8'hE2;

   // Result buffer geometry.
   localparam int unsigned OUT_DEPTH = 4;
   localparam int unsigned OUT_PTR_W = 2;
   localparam int unsigned OUT_CNT_W = 3;

   // One input item.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
   } req_item_type;

   // One result item.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_item_type;

   // Parser phases.
   typedef enum logic [2:0] {
      PH_HEAD   = 3'd0,
      PH_PASS   = 3'd1,
      PH_HELD   = 3'd2,
      PH_LEN_HI = 3'd3,
      PH_LEN_LO = 3'd4,
      PH_SKIP   = 3'd5
   } phase_type;

   // Results produced by the parser for one item: zero, one or two.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } parse_out_type;

endpackage

>>> sv/jasp_parser.sv
// Segment parser of the JPEG APP segment stripper.
// Holds phase and length state; decodes one item per cycle while advance is set.
// Depends on jasp_pkg.
module jasp_parser
   import jasp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  req_item_type  item,
   input  logic          keep_color_profile,
   output parse_out_type result
);

   phase_type   phase_ff, phase_in;
   logic        head_second_ff, head_second_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic [15:0] skip_left_ff, skip_left_in;

   // A new file restarts the parser before its first byte is handled.
   phase_type   phase_now;
   logic        head_second_now;
   logic [7:0]  data;
   logic        is_segment;
   logic        keep_segment;
   logic [15:0] seg_length;
   logic [15:0] seg_skip;

   always_comb begin
      phase_now       = item.file_start ? PH_HEAD : phase_ff;
      head_second_now = item.file_start ? 1'b0 : head_second_ff;
      data            = item.data_byte;
      is_segment      = ((data & APP_MASK) == APP_BASE) || (data == COM_BYTE);
      keep_segment    = (data == APP2_BYTE) && keep_color_profile;
      seg_length      = {length_high_ff, data};
      seg_skip        = (seg_length < 16'd2) ? 16'd0 : (seg_length - 16'd2);
   end

   // Next-state logic.
   always_comb begin
      phase_in       = phase_now;
      head_second_in = head_second_now;
      length_high_in = length_high_ff;
      skip_left_in   = skip_left_ff;
      unique case (phase_now)
         PH_HEAD: begin
            head_second_in = 1'b1;
            if (head_second_now) begin
               phase_in = PH_PASS;
            end
         end
         PH_HELD: begin
            phase_in = (is_segment && !keep_segment) ? PH_LEN_HI : PH_PASS;
         end
         PH_LEN_HI: begin
            length_high_in = data;
            phase_in       = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            skip_left_in = seg_skip;
            phase_in     = (seg_skip == 16'd0) ? PH_PASS : PH_SKIP;
         end
         PH_SKIP: begin
            if (skip_left_ff != 16'd0) begin
               skip_left_in = skip_left_ff - 16'd1;
            end
            if (skip_left_ff <= 16'd1) begin
               phase_in = PH_PASS;
            end
         end
         default: begin
            phase_in = (data == MARK_BYTE) ? PH_HELD : PH_PASS;
         end
      endcase
   end

   // Result decode.
   always_comb begin
      result = '0;
      unique case (phase_now) inside
         PH_HEAD: begin
            result.count          = 2'd1;
            result.first.out_byte = head_second_now ? SOI_BYTE : MARK_BYTE;
            result.first.last     = 1'b1;
         end
         PH_HELD: begin
            if (!(is_segment && !keep_segment)) begin
               result.count           = 2'd2;
               result.first.out_byte  = MARK_BYTE;
               result.first.last      = 1'b0;
               result.second.out_byte = data;
               result.second.last     = 1'b1;
            end
         end
         PH_LEN_HI, PH_LEN_LO, PH_SKIP: begin
            result.count = 2'd0;
         end
         default: begin
            if (data != MARK_BYTE) begin
               result.count          = 2'd1;
               result.first.out_byte = data;
               result.first.last     = 1'b1;
            end
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEAD;
         head_second_ff <= 1'b0;
         length_high_ff <= 8'd0;
         skip_left_ff   <= 16'd0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         head_second_ff <= head_second_in;
         length_high_ff <= length_high_in;
         skip_left_ff   <= skip_left_in;
      end
   end

endmodule

>>> sv/jasp_out_fifo.sv
// Result buffer of the JPEG APP segment stripper.
// Takes up to two result items per cycle and hands one per cycle to the port while it is ready.
// Depends on jasp_pkg.
module jasp_out_fifo
   import jasp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  parse_out_type push,
   output logic          has_room,
   output logic          out_valid,
   input  logic          out_ready,
   output rsp_item_type  out_item
);

   rsp_item_type           entry_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OUT_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;
   logic [OUT_PTR_W-1:0]   wr_next;

   // Room for a two-result item is always kept before the parser advances.
   always_comb begin
      has_room  = count_ff <= OUT_CNT_W'(OUT_DEPTH - 2);
      out_valid = count_ff != '0;
      out_item  = entry_ff[rd_ptr_ff];
      pop       = out_valid && out_ready;
      wr_next   = wr_ptr_ff + OUT_PTR_W'(1);
      wr_ptr_in = wr_ptr_ff + OUT_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + OUT_PTR_W'(pop);
      count_in  = count_ff + OUT_CNT_W'(push.count) - OUT_CNT_W'(pop);
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

>>> sv/jpeg_app_segment_stripper.sv
// Top level of the JPEG APP segment stripper.
// Uses jasp_pkg, jasp_parser and jasp_out_fifo.
//
// Usage:
// The req channel takes one stream byte per item with a file_start flag
// that restarts the parser at the first byte of a new file. The rsp channel
// returns the filtered stream: zero, one or two items per input byte, with
// last set on the final result that a byte causes. APP0..APP15 and COM
// segments are removed; APP2 stays when csr keep_color_profile is 1.
// csr_we writes keep_color_profile from csr_wdata; write only while idle.
// A byte is held in the input register, decoded by the parser and then
// written into the result buffer, which drives the rsp channel.
// One byte per cycle is taken while the result buffer has room; a byte
// that yields a marker pair leaves as two items on the single-item rsp port.
// The input register advances only while the four-entry result buffer has
// room for two items, so a stalled receiver backs pressure up to req_ready
// after at most a few items.
// Reset (synchronous, active high) empties the buffer, sets the parser to
// expect the start bytes and sets keep_color_profile to 1.
module jpeg_app_segment_stripper
   import jasp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item,
   input  logic         csr_we,
   input  logic         csr_wdata
);

   logic          keep_ff;
   logic          stage_valid_ff, stage_valid_in;
   req_item_type  stage_item_ff;
   logic          has_room;
   logic          advance;
   parse_out_type parsed;
   parse_out_type push;

   // Input register handshake.
   always_comb begin
      advance        = stage_valid_ff && has_room;
      req_ready      = !stage_valid_ff || has_room;
      stage_valid_in = req_valid || (stage_valid_ff && !has_room);
      push           = advance ? parsed : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_item_ff <= req_item;
      end
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= 1'b1;
      end else if (csr_we) begin
         keep_ff <= csr_wdata;
      end
   end

   jasp_parser u_parser (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .item               (stage_item_ff),
      .keep_color_profile (keep_ff),
      .result             (parsed)
   );

   jasp_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (rsp_item)
   );

endmodule

>>> sv/jasp_checker.sv
// Port checker for the JPEG APP segment stripper.
// Watches the top-level ports only; bound to jpeg_app_segment_stripper.
// Depends on jasp_pkg.
module jasp_checker
   import jasp_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_item
);

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // Reset leaves the input side free to take an item.
   a_reset_ready: assert property (@(posedge clock) reset |=> req_ready)
      else $error("input not ready after reset");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

   // Only the marker byte of a pair is sent without last.
   a_pair_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last |-> rsp_item.out_byte == MARK_BYTE)
      else $error("non-final result is not a marker byte");

endmodule

bind jpeg_app_segment_stripper jasp_checker u_checker (.*);

>>> tb/sv/tb_jpeg_app_segment_stripper.sv
// Self-checking testbench for jpeg_app_segment_stripper.
// Depends on jasp_pkg for the item types, phase codes and marker byte values.
// A queue-fed driver, a clocked monitor and a byte-level parser model check every result.
module tb_jpeg_app_segment_stripper;
   import jasp_pkg::*;

   localparam int unsigned STALL_LIMIT  = 5000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam logic [7:0]  EOI_BYTE     = 8'hD9;

   // Opening stream with the reset setting (APP2 kept), no file_start at all.
   localparam logic [7:0] OPENING_BYTES [15] = '{
      8'h00, 8'h00, 8'hFF, 8'hE2, 8'h00, 8'h04, 8'hFF, 8'hE1,
      8'h00, 8'h02, 8'h41, 8'hFF, 8'hFF, 8'hFF, EOI_BYTE};
   // Second file with APP2 stripped: short length, then COM with one skipped byte.
   localparam logic [7:0] STRIP_BYTES [12] = '{
      8'hFF, 8'h12, 8'hFF, 8'hE2, 8'h00, 8'h01, 8'hFF, 8'hFE,
      8'h00, 8'h03, 8'hAB, 8'h7F};

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_we    = 1'b0;
   logic         csr_wdata = 1'b0;

   // Stimulus and scoreboard storage.
   req_item_type pending_items[$];
   rsp_item_type expected_out[$];
   int unsigned  send_idle_pct = 30;
   int unsigned  recv_idle_pct = 79;
   int unsigned  issued_cnt    = 0;
   int unsigned  taken_cnt     = 0;
   int unsigned  checked_cnt   = 0;
   int unsigned  items_added   = 0;
   int unsigned  files_added   = 0;
   int unsigned  error_count   = 0;
   int unsigned  stall_cycles  = 0;

   // Parser model state, written only by the monitor.
   phase_type    prs_phase  = PH_HEAD;
   logic [1:0]   prs_head   = '0;
   logic [7:0]   prs_len_hi = '0;
   logic [15:0]  prs_skip   = '0;
   logic         keep_icc   = 1'b1;

   jpeg_app_segment_stripper dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the parser model by one byte and queue the bytes it emits.
   task automatic predict_filtered(input req_item_type it);
      logic [15:0] seg_len;
      logic        is_seg;
      if (it.file_start) begin
         prs_phase  = PH_HEAD;
         prs_head   = '0;
         prs_len_hi = '0;
         prs_skip   = '0;
      end
      case (prs_phase)
         PH_HEAD: begin
            if (prs_head == 2'd0) begin
               prs_head = 2'd1;
               expected_out.push_back(rsp_item_type'{out_byte: MARK_BYTE, last: 1'b1});
            end else begin
               prs_head  = 2'd2;
               prs_phase = PH_PASS;
               expected_out.push_back(rsp_item_type'{out_byte: SOI_BYTE, last: 1'b1});
            end
         end
         PH_HELD: begin
            is_seg = ((it.data_byte & APP_MASK) == APP_BASE) || (it.data_byte == COM_BYTE);
            if (is_seg && !((it.data_byte == APP2_BYTE) && keep_icc)) begin
               prs_phase = PH_LEN_HI;
            end else begin
               prs_phase = PH_PASS;
               expected_out.push_back(rsp_item_type'{out_byte: MARK_BYTE, last: 1'b0});
               expected_out.push_back(rsp_item_type'{out_byte: it.data_byte, last: 1'b1});
            end
         end
         PH_LEN_HI: begin
            prs_len_hi = it.data_byte;
            prs_phase  = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            seg_len   = {prs_len_hi, it.data_byte};
            prs_skip  = (seg_len < 16'd2) ? 16'd0 : seg_len - 16'd2;
            prs_phase = (prs_skip == 16'd0) ? PH_PASS : PH_SKIP;
         end
         PH_SKIP: begin
            if (prs_skip != 16'd0) prs_skip = prs_skip - 16'd1;
            if (prs_skip == 16'd0) prs_phase = PH_PASS;
         end
         default: begin
            if (it.data_byte == MARK_BYTE) begin
               prs_phase = PH_HELD;
            end else begin
               prs_phase = PH_PASS;
               expected_out.push_back(rsp_item_type'{out_byte: it.data_byte, last: 1'b1});
            end
         end
      endcase
   endtask

   // Monitor: register writes, accepted bytes and returned results at the rising edge.
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         prs_phase  = PH_HEAD;
         prs_head   = '0;
         prs_len_hi = '0;
         prs_skip   = '0;
         keep_icc   = 1'b1;
      end else begin
         if (csr_we) keep_icc = csr_wdata;
         if (req_valid && req_ready) begin
            predict_filtered(req_item);
            taken_cnt <= taken_cnt + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_out.size() == 0) begin
               $error("unexpected result item: out_byte %h last %b",
                      rsp_item.out_byte, rsp_item.last);
               error_count++;
            end else begin
               want = expected_out.pop_front();
               checked_cnt++;
               if (rsp_item.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, actual %h", want.out_byte, rsp_item.out_byte);
                  error_count++;
               end
               if (rsp_item.last !== want.last) begin
                  $error("last: expected %b, actual %b", want.last, rsp_item.last);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_jpeg_app_segment_stripper: done, errors");
            $finish;
         end
      end
   end

   // Driver: presents the next pending item and sets receiver backpressure.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         // A presented item holds until the monitor has seen it accepted.
         if (taken_cnt == issued_cnt) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_item   <= pending_items.pop_front();
               req_valid  <= 1'b1;
               issued_cnt <= issued_cnt + 1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic add_byte(input logic [7:0] value, input logic starts_file);
      pending_items.push_back(req_item_type'{data_byte: value, file_start: starts_file});
      items_added++;
      if (starts_file) files_added++;
   endtask

   // Wait until every byte is in and every expected result is out.
   task automatic wait_drained();
      while (pending_items.size() != 0 || taken_cnt != issued_cnt || expected_out.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_keep(input logic value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // One file: random head bytes, then a mix of plain runs, marker segments,
   // bare marker pairs, noise and at times a segment cut off by the next file.
   task automatic gen_file();
      int          n_chunks;
      int          pick;
      logic [7:0]  mk;
      logic [15:0] seg_len;
      add_byte(8'($urandom_range(255)), 1'b1);
      add_byte(8'($urandom_range(255)), 1'b0);
      n_chunks = $urandom_range(12, 2);
      for (int c = 0; c < n_chunks; c++) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            repeat ($urandom_range(8, 1)) add_byte(8'($urandom_range(254)), 1'b0);
         end else if (pick < 80) begin
            case ($urandom_range(3))
               0:       mk = APP_BASE | 8'($urandom_range(15));
               1:       mk = APP2_BYTE;
               2:       mk = COM_BYTE;
               default: mk = 8'($urandom_range(255));
            endcase
            add_byte(MARK_BYTE, 1'b0);
            add_byte(mk, 1'b0);
            if (((mk & APP_MASK) == APP_BASE) || mk == COM_BYTE) begin
               pick = $urandom_range(99);
               if (pick < 5)       seg_len = 16'($urandom_range(1));
               else if (pick < 10) seg_len = 16'd2;
               else if (pick < 95) seg_len = 16'($urandom_range(20, 3));
               else                seg_len = 16'($urandom_range(600, 21));
               add_byte(seg_len[15:8], 1'b0);
               add_byte(seg_len[7:0], 1'b0);
               if (seg_len > 16'd2)
                  repeat (int'(seg_len) - 2) add_byte(8'($urandom_range(255)), 1'b0);
            end
         end else if (pick < 90) begin
            add_byte(MARK_BYTE, 1'b0);
            case ($urandom_range(3))
               0:       add_byte(EOI_BYTE, 1'b0);
               1:       add_byte(MARK_BYTE, 1'b0);
               2:       add_byte(8'h00, 1'b0);
               default: add_byte(8'($urandom_range(255)), 1'b0);
            endcase
         end else if (pick < 95) begin
            // Huge COM length; the next file start must abandon the skip.
            add_byte(MARK_BYTE, 1'b0);
            add_byte(COM_BYTE, 1'b0);
            add_byte(8'($urandom_range(255, 1)), 1'b0);
            add_byte(8'($urandom_range(255)), 1'b0);
            repeat ($urandom_range(5)) add_byte(8'($urandom_range(255)), 1'b0);
            break;
         end else begin
            repeat ($urandom_range(6, 1))
               add_byte(8'($urandom_range(255)), ($urandom_range(15) == 0));
         end
      end
   endtask

   task automatic gen_random_files(input int unsigned n_items);
      int unsigned stop_at;
      stop_at = items_added + n_items;
      while (items_added < stop_at) gen_file();
   endtask

   // Main sequence: reset, directed files, then random files in three idling modes.
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sender idles 30 percent, receiver 79 percent.
      send_idle_pct = 30;
      recv_idle_pct = 79;
      foreach (OPENING_BYTES[i]) add_byte(OPENING_BYTES[i], 1'b0);
      write_keep(1'b0);
      foreach (STRIP_BYTES[i]) add_byte(STRIP_BYTES[i], (i == 0));
      write_keep(1'b1);
      gen_random_files(330);
      write_keep(1'b0);
      gen_random_files(330);

      // Roles swapped.
      write_keep(1'b1);
      send_idle_pct = 79;
      recv_idle_pct = 30;
      gen_random_files(660);

      // No idling on either side.
      write_keep(1'b0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      gen_random_files(330);
      write_keep(1'b1);
      gen_random_files(330);

      wait_drained();
      $display("Run covered %0d input bytes in %0d files and %0d checked result items,",
               taken_cnt, files_added, checked_cnt);
      $display("with APP2 both kept and stripped under three idling mixes.");
      if (error_count == 0) begin
         $display("tb_jpeg_app_segment_stripper: done, clean");
      end else begin
         $display("tb_jpeg_app_segment_stripper: done, errors");
      end
      $finish;
   end

endmodule

>>> files.f
sv/jasp_pkg.sv
sv/jasp_parser.sv
sv/jasp_out_fifo.sv
sv/jpeg_app_segment_stripper.sv
sv/jasp_checker.sv
tb/sv/tb_jpeg_app_segment_stripper.sv
